### design/zdac_pkg.sv
// Package for the z-drop alignment checker: command codes, register map,
// register reset values and fixed field widths. No dependencies.
package zdac_pkg;

  // Default width of a sequence position, without its sign bit
  localparam int POS_BITS_DEF = 24;

  // Fixed field widths
  localparam int SCORE_W    = 32;
  localparam int DELTA_W    = SCORE_W + 1;
  localparam int PEN_W      = 7;
  localparam int ZDROP_W    = 16;
  localparam int LEN_W      = 24;
  localparam int BASE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Alignment element codes
  typedef enum logic [1:0] {
    CMD_PAIR = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_SKIP = 2'd3
  } cmd_t;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH    = 3'd0,
    REG_MISMATCH = 3'd1,
    REG_GAP_OPEN = 3'd2,
    REG_GAP_EXT  = 3'd3,
    REG_ZDROP    = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [PEN_W-1:0]   MATCH_RST    = 7'd2;
  localparam logic [PEN_W-1:0]   MISMATCH_RST = 7'd4;
  localparam logic [PEN_W-1:0]   GAP_OPEN_RST = 7'd4;
  localparam logic [PEN_W-1:0]   GAP_EXT_RST  = 7'd2;
  localparam logic [ZDROP_W-1:0] ZDROP_RST    = 16'd400;

endpackage

### design/zdrop_alignment_checker.sv
// A last request passes through the input register and then the output register.
// Throughput: one request per cycle; a last request waits in the input
// register only while a previous result is stalled at the output.
// The score update and z-drop test are combinational from the input register.
// Reset (rst_n, synchronous): registers return to their defaults, the
// alignment state clears, both pipeline registers empty.
// Top level of the z-drop alignment checker; depends on zdac_pkg.
module zdrop_alignment_checker
  import zdac_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_cmd,
  input  logic [BASE_W-1:0]     in_query_base,
  input  logic [BASE_W-1:0]     in_target_base,
  input  logic [LEN_W-1:0]      in_run_length,
  input  logic                  in_last_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_dropped,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW   = POS_BITS + 1;          // position width with sign
  localparam int DW   = PW + 3;                // diagonal difference width
  localparam int PRW  = PW + 1 + PEN_W;        // shift * gap_extend width
  localparam int CW   = (PRW + 2 > DELTA_W + 1) ? PRW + 2 : DELTA_W + 1;
  localparam int GPW  = LEN_W + PEN_W;         // gap penalty width

  // Configuration registers
  logic [PEN_W-1:0]   match_r, mism_r, gopen_r, gext_r;
  logic [ZDROP_W-1:0] zthr_r;

  // Input register
  logic                      s1_valid_r;
  logic signed [DELTA_W-1:0] s1_delta_r;
  cmd_t                      s1_cmd_r;
  logic [LEN_W-1:0]          s1_len_r;
  logic                      s1_last_r;

  // Alignment state
  logic signed [SCORE_W-1:0] score_r, best_r;
  logic [PW-1:0]             tp_r, qp_r, btp_r, bqp_r;
  logic                      drop_r;

  // Output register
  logic out_valid_r, out_dropped_r;

  // Stage 1 and stage 2 signals
  logic                      in_accept, advance;
  logic [GPW-1:0]            gap_prod, gap_pen;
  logic signed [DELTA_W-1:0] delta_nxt;
  logic signed [DELTA_W:0]   sum;
  logic signed [SCORE_W-1:0] score_nxt;
  logic [PW-1:0]             len_pw, tp_nxt, qp_nxt, tp_t, qp_t;
  logic signed [DW-1:0]      li, lj, dd, dd_abs;
  logic [PW:0]               d_mag;
  logic [PRW-1:0]            d_prod;
  logic [CW-1:0]             lim;
  logic [DELTA_W-1:0]        gap_diff;
  logic                      do_test, below, drop_hit, drop_nxt;

  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_dropped = out_dropped_r;

  // Handshake: a last request needs the output register free
  assign advance   = s1_valid_r & (~s1_last_r | ~out_valid_r | ~out_stall);
  assign in_stall  = s1_valid_r & ~advance;
  assign in_accept = in_valid & ~in_stall;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= MATCH_RST;
      mism_r  <= MISMATCH_RST;
      gopen_r <= GAP_OPEN_RST;
      gext_r  <= GAP_EXT_RST;
      zthr_r  <= ZDROP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MATCH:    match_r <= cfg_data[PEN_W-1:0];
        REG_MISMATCH: mism_r  <= cfg_data[PEN_W-1:0];
        REG_GAP_OPEN: gopen_r <= cfg_data[PEN_W-1:0];
        REG_GAP_EXT:  gext_r  <= cfg_data[PEN_W-1:0];
        REG_ZDROP:    zthr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: score delta of the request
  assign gap_prod = gext_r * in_run_length;
  assign gap_pen  = gap_prod + GPW'(gopen_r);

  always_comb begin
    delta_nxt = '0;
    case (cmd_t'(in_cmd)) inside
      CMD_PAIR: begin
        // N or any code above T scores nothing
        if (!in_query_base[2] && !in_target_base[2]) begin
          if (in_query_base == in_target_base)
            delta_nxt = $signed(DELTA_W'(match_r));
          else
            delta_nxt = -$signed(DELTA_W'(mism_r));
        end
      end
      CMD_INS, CMD_DEL: delta_nxt = -$signed(DELTA_W'(gap_pen));
      default: delta_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_delta_r <= delta_nxt;
      s1_cmd_r   <= cmd_t'(in_cmd);
      s1_len_r   <= in_run_length;
      s1_last_r  <= in_last_item;
    end
  end

  // Stage 2: saturating score update
  assign sum = {score_r[SCORE_W-1], score_r[SCORE_W-1], score_r}
             + {s1_delta_r[DELTA_W-1], s1_delta_r};

  always_comb begin
    if (sum[DELTA_W:SCORE_W-1] == '0 || sum[DELTA_W:SCORE_W-1] == '1)
      score_nxt = sum[SCORE_W-1:0];
    else if (sum[DELTA_W])
      score_nxt = {1'b1, {(SCORE_W-1){1'b0}}};
    else
      score_nxt = {1'b0, {(SCORE_W-1){1'b1}}};
  end

  // Position advance; a pair is tested before it moves, a gap after
  assign len_pw = PW'(s1_len_r);

  always_comb begin
    tp_nxt = tp_r;
    qp_nxt = qp_r;
    case (s1_cmd_r)
      CMD_PAIR: begin
        tp_nxt = tp_r + PW'(1);
        qp_nxt = qp_r + PW'(1);
      end
      CMD_INS: qp_nxt = qp_r + len_pw;
      CMD_DEL: tp_nxt = tp_r + len_pw;
      default: ;
    endcase
  end

  assign tp_t = (s1_cmd_r == CMD_PAIR) ? tp_r : tp_nxt;
  assign qp_t = (s1_cmd_r == CMD_PAIR) ? qp_r : qp_nxt;

  // Diagonal shift from the best point and the allowed drop
  assign li     = $signed({{3{tp_t[PW-1]}}, tp_t}) - $signed({{3{btp_r[PW-1]}}, btp_r});
  assign lj     = $signed({{3{qp_t[PW-1]}}, qp_t})
                - $signed({{3{bqp_r[PW-1]}}, bqp_r});
  assign dd     = li - lj;
  assign dd_abs = dd[DW-1] ? -dd : dd;
  assign d_mag  = dd_abs[PW:0];
  assign d_prod = d_mag * gext_r;
  assign lim    = CW'(d_prod) + CW'(zthr_r);

  // Z-drop test
  assign do_test  = (s1_cmd_r != CMD_SKIP);
  assign below    = score_nxt < best_r;
  assign gap_diff = {best_r[SCORE_W-1], best_r} - {score_nxt[SCORE_W-1], score_nxt};
  assign drop_hit = do_test & below & (CW'(gap_diff) > lim);
  assign drop_nxt = drop_r | drop_hit;

  // State commit; a last request clears the state
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && s1_last_r)) begin
      score_r <= '0;
      best_r  <= '0;
      tp_r    <= '0;
      qp_r    <= '0;
      btp_r   <= '1;
      bqp_r   <= '1;
      drop_r  <= 1'b0;
    end else if (advance) begin
      score_r <= score_nxt;
      tp_r    <= tp_nxt;
      qp_r    <= qp_nxt;
      drop_r  <= drop_nxt;
      if (do_test && !below) begin
        best_r <= score_nxt;
        btp_r  <= tp_t;
        bqp_r  <= qp_t;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_dropped_r <= drop_nxt;
    end
  end

endmodule

### design/zdac_checker.sv
// Port-level checks for the z-drop alignment checker, bound to its top level.
// Depends only on the top level's ports.
module zdac_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_last_item,
  input logic out_valid,
  input logic out_stall,
  input logic out_dropped
);

  // Output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input side stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // A last request reaches the output register once the path is open
  a_last_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_item) ##1 (!out_valid || !out_stall)
    |=> out_valid)
    else $error("result missing after last request");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_dropped)))
    else $error("stalled result changed");

endmodule

bind zdrop_alignment_checker zdac_checker u_zdac_checker (.*);

### test/tb_zdrop_alignment_checker.sv
// Self-checking testbench for zdrop_alignment_checker: streams alignments under several
// register settings and checks every drop flag against an in-bench score tracker.
// Depends on zdac_pkg and the zdrop_alignment_checker RTL.
module tb_zdrop_alignment_checker;
  import zdac_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = POS_BITS_DEF + 1;
  localparam logic [BASE_W-1:0] BASE_N = 3'd4;
  localparam logic [LEN_W-1:0]  LEN_MAX = {LEN_W{1'b1}};
  localparam int IDLE_PCT = 34;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    cmd_t              cmd;
    logic [BASE_W-1:0] qb;
    logic [BASE_W-1:0] tb;
    logic [LEN_W-1:0]  len;
    logic              last;
  } align_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = CMD_SKIP;
  logic [BASE_W-1:0] in_query_base = '0;
  logic [BASE_W-1:0] in_target_base = '0;
  logic [LEN_W-1:0] in_run_length = '0;
  logic in_last_item = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_dropped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MATCH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  zdrop_alignment_checker uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_query_base  (in_query_base),
    .in_target_base (in_target_base),
    .in_run_length  (in_run_length),
    .in_last_item   (in_last_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dropped    (out_dropped),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Stream of requests waiting to go out, and drop flags still owed by the block
  align_req_t align_stream[$];
  bit expected_drops[$];
  align_req_t bus_req;
  bit steady_flow = 1'b0;

  int errors = 0;
  int n_elements = 0;
  int n_alignments = 0;
  int n_dropped = 0;
  int n_settings = 0;

  // Tracker copy of the registers
  longint cf_match  = MATCH_RST;
  longint cf_mis    = MISMATCH_RST;
  longint cf_gopen  = GAP_OPEN_RST;
  longint cf_gext   = GAP_EXT_RST;
  longint cf_zdrop  = ZDROP_RST;

  // Tracker copy of the alignment state
  longint sc_run, sc_best;
  logic [PW-1:0] tpos, qpos, best_tpos, best_qpos;
  bit drop_flag;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint pos_val(input logic [PW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > longint'(32'sh7fff_ffff)) return longint'(32'sh7fff_ffff);
    if (v < -longint'(64'sh8000_0000)) return -longint'(64'sh8000_0000);
    return v;
  endfunction

  task automatic clear_track();
    sc_run = 0;
    sc_best = 0;
    best_tpos = '1;
    best_qpos = '1;
    tpos = '0;
    qpos = '0;
    drop_flag = 1'b0;
  endtask

  // New best score, or test the drop against the diagonal-weighted threshold
  task automatic test_point();
    longint li, lj, d, lim;
    if (sc_run < sc_best) begin
      li = pos_val(tpos) - pos_val(best_tpos);
      lj = pos_val(qpos) - pos_val(best_qpos);
      d = (li > lj) ? li - lj : lj - li;
      lim = cf_zdrop + d * cf_gext;
      if (sc_best - sc_run > lim) drop_flag = 1'b1;
    end else begin
      sc_best = sc_run;
      best_tpos = tpos;
      best_qpos = qpos;
    end
  endtask

  // Apply one alignment element; the last one yields the flag and clears the state
  task automatic score_element(input align_req_t r, output bit produced, output bit flag);
    longint delta, pen;
    produced = 1'b0;
    flag = 1'b0;
    case (r.cmd)
      CMD_PAIR: begin
        delta = 0;
        if (r.qb < BASE_N && r.tb < BASE_N) delta = (r.qb == r.tb) ? cf_match : -cf_mis;
        sc_run = clamp32(sc_run + delta);
        test_point();
        tpos = tpos + 1'b1;
        qpos = qpos + 1'b1;
      end
      CMD_INS, CMD_DEL: begin
        pen = cf_gopen + cf_gext * longint'(r.len);
        sc_run = clamp32(sc_run - pen);
        if (r.cmd == CMD_INS) qpos = qpos + r.len;
        else tpos = tpos + r.len;
        test_point();
      end
      default: ;
    endcase
    if (r.last) begin
      produced = 1'b1;
      flag = drop_flag;
      clear_track();
    end
  endtask

  // Request driver: predict on acceptance, then maybe present the next request
  always @(posedge clk) begin : drive_stream
    bit produced;
    bit flag;
    if (in_valid && !in_stall) begin
      score_element(bus_req, produced, flag);
      n_elements++;
      if (produced) expected_drops.push_back(flag);
    end
    if (!in_valid || !in_stall) begin
      if (align_stream.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
        bus_req = align_stream.pop_front();
        in_valid       <= 1'b1;
        in_cmd         <= bus_req.cmd;
        in_query_base  <= bus_req.qb;
        in_target_base <= bus_req.tb;
        in_run_length  <= bus_req.len;
        in_last_item   <= bus_req.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin : check_results
    bit want;
    if (out_valid && !out_stall) begin
      if (expected_drops.size() == 0) begin
        report_mismatch($sformatf("unexpected result, dropped=%0b", out_dropped));
      end else begin
        want = expected_drops.pop_front();
        n_alignments++;
        if (want) n_dropped++;
        if (out_dropped !== want)
          report_mismatch($sformatf("dropped=%0b, expected %0b", out_dropped, want));
      end
    end
    out_stall <= steady_flow ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  task automatic add_req(input cmd_t cmd, input logic [BASE_W-1:0] qb,
                         input logic [BASE_W-1:0] tb, input logic [LEN_W-1:0] len,
                         input logic last);
    align_req_t r;
    r.cmd = cmd;
    r.qb = qb;
    r.tb = tb;
    r.len = len;
    r.last = last;
    align_stream.push_back(r);
  endtask

  // Wait until every request is out and every flag is back, then let the pipe settle
  task automatic drain_alignments();
    do @(posedge clk);
    while (align_stream.size() != 0 || in_valid || expected_drops.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; cfg_valid stays high for the next write in the sequence
  task automatic cfg_write(input cfg_reg_t idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_MATCH:    cf_match = value & 'h7f;
      REG_MISMATCH: cf_mis   = value & 'h7f;
      REG_GAP_OPEN: cf_gopen = value & 'h7f;
      REG_GAP_EXT:  cf_gext  = value & 'h7f;
      REG_ZDROP:    cf_zdrop = value & 'hffff;
      default: ;
    endcase
  endtask

  task automatic set_regs(input int unsigned m, input int unsigned mm, input int unsigned go,
                          input int unsigned ge, input int unsigned zd);
    cfg_write(REG_MATCH, m);
    cfg_write(REG_MISMATCH, mm);
    cfg_write(REG_GAP_OPEN, go);
    cfg_write(REG_GAP_EXT, ge);
    cfg_write(REG_ZDROP, zd);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 93) return LEN_W'($urandom_range(1, 8));
    return LEN_W'($urandom);
  endfunction

  // One alignment with random content; a few are single elements or only ignored ops
  task automatic gen_alignment(output int counted);
    int n, roll, match_pct;
    logic [BASE_W-1:0] qb, tb;
    bit junk;
    counted = 0;
    roll = $urandom_range(99);
    junk = (roll < 5);
    n = (roll < 12) ? 1 : $urandom_range(2, 16);
    match_pct = $urandom_range(30, 95);
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (junk || roll >= 95) begin
        add_req(CMD_SKIP, BASE_W'($urandom), BASE_W'($urandom), LEN_W'($urandom), k == n - 1);
      end else if (roll < 70) begin
        if ($urandom_range(99) < 10) begin
          qb = BASE_W'($urandom);
          tb = BASE_W'($urandom);
        end else begin
          qb = BASE_W'($urandom_range(0, 3));
          tb = ($urandom_range(99) < match_pct) ? qb : BASE_W'($urandom_range(0, 3));
        end
        add_req(CMD_PAIR, qb, tb, LEN_W'($urandom), k == n - 1);
        counted++;
      end else begin
        add_req((roll < 83) ? CMD_INS : CMD_DEL, BASE_W'($urandom), BASE_W'($urandom),
                pick_len(), k == n - 1);
        counted++;
      end
    end
  endtask

  task automatic run_random(input int target);
    int done, got;
    done = 0;
    while (done < target) begin
      gen_alignment(got);
      done += got;
    end
  endtask

  initial begin
    clear_track();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: every op, base codes incl. N and the unused codes,
    // zero-length gaps, ignored op carrying the end mark, empty alignment
    add_req(CMD_PAIR, 3'd0, 3'd0, '0, 1'b0);
    add_req(CMD_PAIR, 3'd1, 3'd2, LEN_MAX, 1'b0);
    add_req(CMD_PAIR, BASE_N, 3'd3, '0, 1'b0);
    add_req(CMD_PAIR, 3'd5, 3'd5, '0, 1'b0);
    add_req(CMD_PAIR, 3'd7, 3'd6, '0, 1'b0);
    add_req(CMD_INS, 3'd7, 3'd7, '0, 1'b0);
    add_req(CMD_DEL, 3'd0, 3'd0, '0, 1'b0);
    add_req(CMD_SKIP, 3'd7, 3'd7, LEN_MAX, 1'b1);
    add_req(CMD_SKIP, 3'd0, 3'd0, '0, 1'b1);
    drain_alignments();

    // Zero threshold: drop on first mismatch, flag stays while tracking goes on;
    // then long insertions wrap the query position
    set_regs(127, 127, 127, 0, 0);
    add_req(CMD_PAIR, 3'd2, 3'd2, '0, 1'b0);
    add_req(CMD_PAIR, 3'd0, 3'd1, '0, 1'b0);
    add_req(CMD_PAIR, 3'd3, 3'd3, '0, 1'b0);
    add_req(CMD_PAIR, 3'd1, 3'd1, '0, 1'b1);
    add_req(CMD_INS, 3'd0, 3'd0, LEN_MAX, 1'b0);
    add_req(CMD_INS, 3'd0, 3'd0, LEN_MAX, 1'b0);
    add_req(CMD_INS, 3'd0, 3'd0, LEN_MAX, 1'b0);
    add_req(CMD_PAIR, 3'd0, 3'd0, '0, 1'b0);
    add_req(CMD_DEL, 3'd0, 3'd0, 24'd1, 1'b1);
    drain_alignments();

    // Maximum registers: two full deletions saturate the score low
    set_regs(127, 127, 127, 127, 65535);
    add_req(CMD_DEL, 3'd0, 3'd0, LEN_MAX, 1'b0);
    add_req(CMD_DEL, 3'd0, 3'd0, LEN_MAX, 1'b0);
    add_req(CMD_PAIR, 3'd2, 3'd2, '0, 1'b0);
    add_req(CMD_INS, 3'd0, 3'd0, LEN_MAX, 1'b1);
    drain_alignments();

    // Random alignments across a range of settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_regs(MATCH_RST, MISMATCH_RST, GAP_OPEN_RST, GAP_EXT_RST, ZDROP_RST);
        1: set_regs(0, 0, 0, 0, 0);
        2: set_regs(127, 127, 127, 127, 65535);
        5: set_regs($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 127), $urandom_range(0, 65535));
        default: set_regs($urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(0, 12),
                          $urandom_range(0, 4), $urandom_range(0, 40));
      endcase
      steady_flow = (p == 3);
      run_random(75);
      drain_alignments();
    end
    steady_flow = 1'b0;

    $display("Ran %0d elements, %0d alignments checked (%0d flagged a drop),",
             n_elements, n_alignments, n_dropped);
    $display("over %0d register settings with random idle and back-pressure.", n_settings);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("Timeout with %0d results outstanding", expected_drops.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
design/zdac_pkg.sv
design/zdrop_alignment_checker.sv
design/zdac_checker.sv
test/tb_zdrop_alignment_checker.sv
